>>> sv/adam_pkg.sv
// Shared types, constants and datapath step functions for the Adam update engine.
// No dependencies; imported by adam_param_update, adam_checker and tb.
package adam_pkg;

  localparam int IDX_W = 12;
  localparam int VAL_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DECAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_DECAY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STABILIZER   = 2'd3;

  localparam logic [CFG_W-1:0] STEP_SIZE_RST    = 16'd66;
  localparam logic [CFG_W-1:0] FIRST_DECAY_RST  = 16'd58982;
  localparam logic [CFG_W-1:0] SECOND_DECAY_RST = 16'd65470;
  localparam logic [CFG_W-1:0] STABILIZER_RST   = 16'd1;

  localparam int SQ_STAGES  = 12;  // 2 root bits per stage, 24-bit root
  localparam int DIV_STAGES = 24;  // 2 quotient bits per stage, 48-bit quotient
  localparam int FIFO_DEPTH = 64;
  localparam int FIFO_AW    = 6;

  typedef struct packed {
    logic        [VAL_W-1:0] r;
    logic signed [VAL_W-1:0] v;
  } moment_t;

  typedef struct packed {
    logic [47:0] x;
    logic [23:0] root;
    logic [25:0] rem;
  } sq_t;

  typedef struct packed {
    logic [47:0] n;
    logic [47:0] q;
    logic [24:0] rem;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t o;
    logic [27:0] rw;
    logic [27:0] trial;
    o = s;
    for (int i = 0; i < 2; i++) begin
      rw = {o.rem, o.x[47:46]};
      trial = {2'b00, o.root, 2'b01};
      o.x = {o.x[45:0], 2'b00};
      if (rw >= trial) begin
        o.rem = 26'(rw - trial);
        o.root = {o.root[22:0], 1'b1};
      end else begin
        o.rem = rw[25:0];
        o.root = {o.root[22:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic dv_t div_step(input dv_t s, input logic [24:0] d);
    dv_t o;
    logic [25:0] rw;
    o = s;
    for (int i = 0; i < 2; i++) begin
      rw = {o.rem, o.n[47]};
      o.n = {o.n[46:0], 1'b0};
      if (rw >= {1'b0, d}) begin
        o.rem = 25'(rw - {1'b0, d});
        o.q = {o.q[46:0], 1'b1};
      end else begin
        o.rem = rw[24:0];
        o.q = {o.q[46:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_s32(input logic signed [49:0] x);
    logic signed [VAL_W-1:0] o;
    if (x > 50'sd2147483647) o = 32'sh7FFFFFFF;
    else if (x < -50'sd2147483648) o = 32'sh80000000;
    else o = x[31:0];
    return o;
  endfunction

endpackage

>>> sv/adam_param_update.sv
// Adam-style parameter update engine (no bias correction), Q16.16 fixed point.
// Depends on adam_pkg. Moments live in one synchronous RAM, results leave via a FIFO.
//
// One item per clock sustained while s_axis_tready is high; an item's result passes
// through the address and moment RAM read registers, the read-modify-write stage,
// 12 root stages, one scaling stage, 24 divider stages, the result FIFO write and
// the output register. After reset the moment RAM is zeroed one entry per clock and
// s_axis_tready stays low meanwhile. Up to 64 items may be in flight; beyond that
// tready drops until results are taken. Back-to-back items on the same element are
// forwarded around the RAM.
module adam_param_update #(
  parameter int ELEMENT_COUNT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // element_index, gradient, current_value
  input  logic [adam_pkg::S_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_index, updated_value
  output logic [adam_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [adam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adam_pkg::CFG_W-1:0]     cfg_data
);
  import adam_pkg::*;

  localparam int AW = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
  localparam logic [24:0] RECIP = 25'((64'd1 << 24) / ELEMENT_COUNT);
  localparam logic [31:0] NCOUNT = 32'(ELEMENT_COUNT);

  // config registers
  logic [CFG_W-1:0] step_size, first_decay, second_decay, stabilizer;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_SIZE_RST;
      first_decay <= FIRST_DECAY_RST;
      second_decay <= SECOND_DECAY_RST;
      stabilizer <= STABILIZER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:    step_size <= cfg_data;
        CFG_FIRST_DECAY:  first_decay <= cfg_data;
        CFG_SECOND_DECAY: second_decay <= cfg_data;
        CFG_STABILIZER:   stabilizer <= cfg_data;
        default:          ;
      endcase
    end
  end

  // clear pass and credit
  logic          clr_active;
  logic [AW-1:0] clr_addr;
  logic [FIFO_AW:0] inflight;
  logic          s_acc, m_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !clr_active && (inflight < (FIFO_AW+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(ELEMENT_COUNT - 1)) clr_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else if (s_acc && !m_acc) inflight <= inflight + 1'b1;
    else if (!s_acc && m_acc) inflight <= inflight - 1'b1;
  end

  // accept: unpack, |g|^2 and address quotient estimate
  logic [IDX_W-1:0]        in_idx;
  logic signed [VAL_W-1:0] in_g, in_p;
  logic [VAL_W-1:0]        in_gmag;

  assign in_idx = s_axis_tdata[11:0];
  assign in_g   = s_axis_tdata[43:12];
  assign in_p   = s_axis_tdata[75:44];
  assign in_gmag = in_g[31] ? 32'(-{in_g[31], in_g}) : in_g;

  logic                    p_valid;
  logic [IDX_W-1:0]        p_idx, p_q;
  logic signed [VAL_W-1:0] p_g, p_p;
  logic [63:0]             p_gg;
  logic [36:0]             in_qprod;

  assign in_qprod = 37'(in_idx) * 37'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else p_valid <= s_acc;
    p_idx <= in_idx;
    p_g <= in_g;
    p_p <= in_p;
    p_gg <= 64'(in_gmag) * 64'(in_gmag);
    p_q <= in_qprod[35:24];
  end

  // address reduction and g^2 rounding
  logic [31:0]   p_qn, p_rem0, p_rem;
  logic [AW-1:0] p_addr;
  logic [63:0]   p_ggr;
  logic [VAL_W-1:0] p_gsq;

  assign p_qn = 32'(p_q) * NCOUNT;
  assign p_rem0 = 32'(p_idx) - p_qn;
  assign p_rem = (p_rem0 >= NCOUNT) ? p_rem0 - NCOUNT : p_rem0;
  assign p_addr = p_rem[AW-1:0];
  assign p_ggr = p_gg + 64'd32768;
  assign p_gsq = (p_ggr[63:48] != '0) ? 32'hFFFFFFFF : p_ggr[47:16];

  // moment RAM
  moment_t       mem [ELEMENT_COUNT];
  moment_t       mem_q, mem_wd;
  logic          mem_we;
  logic [AW-1:0] mem_wa;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[p_addr];
  end

  logic                    a_valid;
  logic [IDX_W-1:0]        a_idx;
  logic [AW-1:0]           a_addr;
  logic signed [VAL_W-1:0] a_g, a_p;
  logic [VAL_W-1:0]        a_gsq;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else a_valid <= p_valid;
    a_idx <= p_idx;
    a_addr <= p_addr;
    a_g <= p_g;
    a_p <= p_p;
    a_gsq <= p_gsq;
  end

  // read-modify-write of the moments
  logic                    sq_valid [SQ_STAGES+1];
  sq_t                     sq_s     [SQ_STAGES+1];
  logic [IDX_W-1:0]        sq_idx   [SQ_STAGES+1];
  logic signed [VAL_W-1:0] sq_p     [SQ_STAGES+1];
  logic signed [VAL_W-1:0] sq_v     [SQ_STAGES+1];
  logic [AW-1:0]           b_addr;
  logic [VAL_W-1:0]        b_r;

  logic                    fwd;
  logic signed [VAL_W-1:0] v_old, vn;
  logic [VAL_W-1:0]        r_old, rn;
  logic [16:0]             c1, c2;
  logic signed [32:0]      dv1, dv2;
  logic signed [50:0]      pr1, pr2, rd1, rd2;
  logic signed [35:0]      vsum, rsum;

  assign fwd = sq_valid[0] && (b_addr == a_addr);
  assign v_old = fwd ? sq_v[0] : mem_q.v;
  assign r_old = fwd ? b_r : mem_q.r;
  assign c1 = 17'h10000 - {1'b0, first_decay};
  assign c2 = 17'h10000 - {1'b0, second_decay};
  assign dv1 = {a_g[31], a_g} - {v_old[31], v_old};
  assign dv2 = $signed({1'b0, a_gsq}) - $signed({1'b0, r_old});
  assign pr1 = $signed({1'b0, c1}) * dv1;
  assign pr2 = $signed({1'b0, c2}) * dv2;
  assign rd1 = (pr1 + 51'sd32768) >>> 16;
  assign rd2 = (pr2 + 51'sd32768) >>> 16;
  assign vsum = {{4{v_old[31]}}, v_old} + rd1[35:0];
  assign rsum = $signed({4'b0, r_old}) + rd2[35:0];
  assign vn = sat_s32({{14{vsum[35]}}, vsum});
  assign rn = rsum[35] ? '0 : ((rsum[34:32] != '0) ? 32'hFFFFFFFF : rsum[31:0]);

  assign mem_we = clr_active || a_valid;
  assign mem_wa = clr_active ? clr_addr : a_addr;
  assign mem_wd = clr_active ? '0 : moment_t'{r: rn, v: vn};

  // square root pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ_STAGES; k++) sq_valid[k] <= 1'b0;
    end else begin
      sq_valid[0] <= a_valid;
      for (int k = 1; k <= SQ_STAGES; k++) sq_valid[k] <= sq_valid[k-1];
    end
    sq_s[0] <= sq_t'{x: {rn, 16'h0000}, root: '0, rem: '0};
    sq_idx[0] <= a_idx;
    sq_p[0] <= a_p;
    sq_v[0] <= vn;
    b_addr <= a_addr;
    b_r <= rn;
    for (int k = 1; k <= SQ_STAGES; k++) begin
      sq_s[k] <= sqrt_step(sq_s[k-1]);
      sq_idx[k] <= sq_idx[k-1];
      sq_p[k] <= sq_p[k-1];
      sq_v[k] <= sq_v[k-1];
    end
  end

  // divisor and rounded numerator
  logic [24:0]      dsum, dval;
  logic signed [VAL_W-1:0] vlast;
  logic [VAL_W-1:0] vmag;
  logic [47:0]      num;

  assign vlast = sq_v[SQ_STAGES];
  assign dsum = {1'b0, sq_s[SQ_STAGES].root} + 25'(stabilizer);
  assign dval = (dsum == '0) ? 25'd1 : dsum;
  assign vmag = vlast[31] ? 32'(-{vlast[31], vlast}) : vlast;
  assign num = 48'(step_size) * 48'(vmag) + 48'(dval[24:1]);

  // divider pipeline
  logic                    dv_valid [DIV_STAGES+1];
  dv_t                     dv_s     [DIV_STAGES+1];
  logic [24:0]             dv_d     [DIV_STAGES+1];
  logic                    dv_neg   [DIV_STAGES+1];
  logic [IDX_W-1:0]        dv_idx   [DIV_STAGES+1];
  logic signed [VAL_W-1:0] dv_p     [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STAGES; k++) dv_valid[k] <= 1'b0;
    end else begin
      dv_valid[0] <= sq_valid[SQ_STAGES];
      for (int k = 1; k <= DIV_STAGES; k++) dv_valid[k] <= dv_valid[k-1];
    end
    dv_s[0] <= dv_t'{n: num, q: '0, rem: '0};
    dv_d[0] <= dval;
    dv_neg[0] <= vlast[31];
    dv_idx[0] <= sq_idx[SQ_STAGES];
    dv_p[0] <= sq_p[SQ_STAGES];
    for (int k = 1; k <= DIV_STAGES; k++) begin
      dv_s[k] <= div_step(dv_s[k-1], dv_d[k-1]);
      dv_d[k] <= dv_d[k-1];
      dv_neg[k] <= dv_neg[k-1];
      dv_idx[k] <= dv_idx[k-1];
      dv_p[k] <= dv_p[k-1];
    end
  end

  // final update
  logic signed [49:0]      ps, qs, pn_w;
  logic signed [VAL_W-1:0] pn;

  assign ps = {{18{dv_p[DIV_STAGES][31]}}, dv_p[DIV_STAGES]};
  assign qs = $signed({2'b00, dv_s[DIV_STAGES].q});
  assign pn_w = dv_neg[DIV_STAGES] ? ps + qs : ps - qs;
  assign pn = sat_s32(pn_w);

  // result FIFO and output register
  logic [IDX_W+VAL_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr, rd_ptr;
  logic [FIFO_AW:0]       fifo_cnt;
  logic                   fifo_wr, fifo_rd;
  logic [IDX_W+VAL_W-1:0] out_q;

  assign fifo_wr = dv_valid[DIV_STAGES];
  assign fifo_rd = (fifo_cnt != '0) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (fifo_wr) fifo_mem[wr_ptr] <= {pn, dv_idx[DIV_STAGES]};
  end

  always_ff @(posedge clk) begin
    if (fifo_rd) out_q <= fifo_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fifo_cnt <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (fifo_wr) wr_ptr <= wr_ptr + 1'b1;
      if (fifo_rd) rd_ptr <= rd_ptr + 1'b1;
      if (fifo_wr && !fifo_rd) fifo_cnt <= fifo_cnt + 1'b1;
      else if (!fifo_wr && fifo_rd) fifo_cnt <= fifo_cnt - 1'b1;
      if (fifo_rd) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {4'b0000, out_q};

  // checks
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("in-flight count above FIFO depth");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s_axis_tready)
    else $error("input ready during RAM clear");

  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (fifo_wr && !fifo_rd) |-> (fifo_cnt < (FIFO_AW+1)'(FIFO_DEPTH)))
    else $error("result FIFO overflow");

  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (inflight != '0))
    else $error("output valid with no item in flight");

  a_no_pipe_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !a_valid)
    else $error("moment update during RAM clear");

endmodule

>>> dv/adam_checker.sv
`timescale 1ns / 100ps
// Checker for adam_param_update: watches config writes and both streams, predicts each
// updated parameter value and compares results in order. Depends on adam_pkg.
module adam_checker #(
  parameter int ELEMENT_COUNT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [adam_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [adam_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input  logic                           cfg_we,
  input  logic [adam_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adam_pkg::CFG_W-1:0]     cfg_data,
  output int                             errors,
  output int                             pending
);
  import adam_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] val;
  } update_t;

  update_t update_q[$];
  logic signed [VAL_W-1:0] first_m[ELEMENT_COUNT];
  logic [VAL_W-1:0]        second_m[ELEMENT_COUNT];
  logic [CFG_W-1:0] alpha, beta1, beta2, eps;

  assign pending = update_q.size();

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [VAL_W-1:0] adam_update(logic [IDX_W-1:0] idx,
      logic signed [VAL_W-1:0] grad, logic signed [VAL_W-1:0] cur);
    int a;
    longint g, v, acc1, vn, stp;
    longint unsigned ga, gsq, acc2, rn, d, vmag, smag;
    a = idx % ELEMENT_COUNT;
    g = grad;
    v = first_m[a];
    acc1 = longint'(beta1) * v + (64'sd65536 - longint'(beta1)) * g + 32768;
    vn = sat32(acc1 >>> 16);
    first_m[a] = vn[31:0];
    ga = (g < 0) ? -g : g;
    gsq = (ga * ga + 32768) >> 16;
    if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
    acc2 = longint'(beta2) * second_m[a] + (65536 - longint'(beta2)) * gsq + 32768;
    rn = acc2 >> 16;
    if (rn > 64'hFFFF_FFFF) rn = 64'hFFFF_FFFF;
    second_m[a] = rn[31:0];
    d = int_root(rn << 16) + eps;
    if (d == 0) d = 1;
    vmag = (vn < 0) ? -vn : vn;
    smag = (longint'(alpha) * vmag + (d >> 1)) / d;
    stp = (vn < 0) ? -longint'(smag) : longint'(smag);
    return 32'(sat32(longint'(cur) - stp));
  endfunction

  always @(posedge clk) begin
    update_t got, want;
    if (rst) begin
      errors <= 0;
      update_q.delete();
      for (int i = 0; i < ELEMENT_COUNT; i++) begin
        first_m[i] = '0;
        second_m[i] = '0;
      end
      alpha = STEP_SIZE_RST;
      beta1 = FIRST_DECAY_RST;
      beta2 = SECOND_DECAY_RST;
      eps = STABILIZER_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_SIZE:    alpha = cfg_data;
          CFG_FIRST_DECAY:  beta1 = cfg_data;
          CFG_SECOND_DECAY: beta2 = cfg_data;
          CFG_STABILIZER:   eps = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want.idx = s_axis_tdata[11:0];
        want.val = adam_update(s_axis_tdata[11:0], s_axis_tdata[43:12],
                               s_axis_tdata[75:44]);
        update_q.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx = m_axis_tdata[11:0];
        got.val = m_axis_tdata[43:12];
        if (update_q.size() == 0) begin
          $error("unexpected result item idx=%0d value=%0d", got.idx, got.val);
          errors <= errors + 1;
        end else begin
          want = update_q.pop_front();
          if (got.idx !== want.idx) begin
            $error("result_index expected %0d actual %0d", want.idx, got.idx);
            errors <= errors + 1;
          end else if (got.val !== want.val) begin
            $error("updated_value expected %0d actual %0d (idx %0d)",
                   want.val, got.val, got.idx);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Top of the adam_param_update testbench: clock, reset, stimulus with bursty input and
// stalling output, config phases and verdict. Depends on adam_pkg, adam_param_update and adam_checker.
module tb;
  import adam_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int errors, pending, burst_left, idle_cycles;

  adam_param_update u_dut (.*);
  adam_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // output side stall pattern: randomly chosen runs of full speed, random, and long stalls
  initial begin
    int mode, run;
    m_axis_tready = 0;
    forever begin
      mode = $urandom_range(0, 2);
      run = $urandom_range(10, 120);
      repeat (run) begin
        @(negedge clk);
        case (mode)
          0: m_axis_tready = 1;
          1: m_axis_tready = $urandom_range(0, 1);
          default: m_axis_tready = ($urandom_range(0, 29) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_item(logic [11:0] idx, logic [31:0] grad, logic [31:0] cur);
    if (burst_left == 0) begin
      @(negedge clk);
      s_axis_tvalid = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tdata = {4'b0, cur, grad, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_all(logic [15:0] a, logic [15:0] b1, logic [15:0] b2,
                         logic [15:0] e);
    write_cfg(CFG_STEP_SIZE, a);
    write_cfg(CFG_FIRST_DECAY, b1);
    write_cfg(CFG_SECOND_DECAY, b2);
    write_cfg(CFG_STABILIZER, e);
  endtask

  task automatic random_items(int n);
    logic [11:0] idx;
    logic [31:0] g, p;
    repeat (n) begin
      idx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: g = $urandom;
        1: g = 32'($signed($urandom_range(0, 2097152)) - 1048576);
        2: g = 32'($signed($urandom_range(0, 131072)) - 65536);
        default: g = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      endcase
      p = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'h7FFFFFF0 : 32'h80000010)
                                      : $urandom;
      send_item(idx, g, p);
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_index = CFG_STEP_SIZE;
    cfg_data = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: field extremes, repeated element, defaults
    send_item(12'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(12'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(12'd4095, 32'h80000000, 32'h80000000);
    send_item(12'd4095, 32'h80000000, 32'h80000000);
    send_item(12'd1, 32'h0, 32'h0);
    send_item(12'd2, 32'hFFFFFFFF, 32'h1);
    send_item(12'd3, 32'h1, 32'hFFFFFFFF);
    send_item(12'd3, 32'h00010000, 32'h00010000);
    send_item(12'd2730, 32'hFFFF0000, 32'h55555555);
    send_item(12'd1365, 32'h00008000, 32'hAAAAAAAA);
    settle();
    // extremes: full step, no memory; zero stabilizer hits zero divisor on zero gradient
    set_all(16'hFFFF, 16'h0, 16'h0, 16'h0);
    send_item(12'd100, 32'h0, 32'h12345678);
    send_item(12'd101, 32'h7FFFFFFF, 32'h80000000);
    send_item(12'd102, 32'h80000000, 32'h7FFFFFFF);
    send_item(12'd103, 32'h00000001, 32'h0);
    send_item(12'd103, 32'hFFFFFFFF, 32'h0);
    settle();
    set_all(16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(12'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(12'd4095, 32'h80000000, 32'h0);
    send_item(12'd5, 32'h00010000, 32'h80000000);
    settle();

    set_all(STEP_SIZE_RST, FIRST_DECAY_RST, SECOND_DECAY_RST, STABILIZER_RST);
    random_items(300);
    settle();
    set_all(16'hFFFF, 16'h0, 16'h0, 16'h0);
    random_items(250);
    settle();
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1);
    random_items(250);
    settle();
    for (int ph = 0; ph < 3; ph++) begin
      set_all(16'($urandom), 16'($urandom), 16'($urandom),
              $urandom_range(0, 1) ? 16'($urandom) : 16'd1);
      random_items(240);
      settle();
    end

    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end
endmodule

>>> filelist.f
sv/adam_pkg.sv
sv/adam_param_update.sv
dv/adam_checker.sv
dv/tb.sv
